[rtl/sts_pkg.sv]
package sts_pkg;

    // Sizing of the scanner.
    localparam longint unsigned MAX_TEXT_BYTES = 64'd1048576;
    localparam int KEYWORD_CHARS = 12;
    localparam int KW_IW = $clog2(KEYWORD_CHARS);
    localparam int KW_W = KEYWORD_CHARS * 8;

    // Saturation limits of positions, lengths and the line/column cursor.
    localparam logic [19:0] POS_CAP =
        20'((MAX_TEXT_BYTES - 64'd1 < 64'hFFFFF) ? MAX_TEXT_BYTES - 64'd1 : 64'hFFFFF);
    localparam logic [20:0] LEN_CAP =
        21'((MAX_TEXT_BYTES < 64'h100000) ? MAX_TEXT_BYTES : 64'h100000);
    localparam logic [20:0] LC_CAP = 21'h100000;

    typedef enum logic [6:0] {
        K_EOQ, K_LPAREN, K_RPAREN, K_COMMA, K_DOT, K_SEMI, K_STAR, K_PLUS,
        K_PERCENT, K_CONCAT, K_MINUS, K_SLASH, K_EQ, K_NE, K_LE, K_LT, K_GE,
        K_GT, K_IDENT, K_FLOAT, K_INTEGER, K_STRING,
        KW_SELECT, KW_FROM, KW_WHERE, KW_ORDER, KW_BY, KW_GROUP, KW_HAVING,
        KW_LIMIT, KW_OFFSET, KW_AS, KW_AND, KW_OR, KW_NOT, KW_NULL, KW_TRUE,
        KW_FALSE, KW_SUM, KW_COUNT, KW_AVG, KW_MIN, KW_MAX, KW_INSERT, KW_INTO,
        KW_VALUES, KW_CREATE, KW_TABLE, KW_DROP, KW_SHOW, KW_DATABASE,
        KW_DESCRIBE, KW_DESC, KW_EXPLAIN, KW_JOIN, KW_LEFT, KW_RIGHT, KW_INNER,
        KW_ON, KW_ALL, KW_WITH, KW_ROLLUP, KW_ARRAY, KW_LATERAL, KW_ANY,
        KW_DISTINCT, KW_ASC, KW_USE, KW_ALTER, KW_IF, KW_EXISTS, KW_ENGINE,
        KW_TRUNCATE, KW_DETACH, KW_ADD, KW_COLUMN, KW_MODIFY, KW_IN, KW_OVER,
        KW_PARTITION, KW_VIEW, KW_VIEWS, KW_MATERIALIZED, KW_REFRESH,
        KW_STORAGE, KW_UNIT, KW_UNITS, KW_TYPE, KW_PATH, KW_BUCKET,
        KW_ENDPOINT, KW_REGION, KW_USAGE
    } kind_t;

    typedef logic [KEYWORD_CHARS-1:0][7:0] wbuf_t;

    typedef struct packed {
        kind_t       kind;
        logic [19:0] off;
        logic [20:0] len;
        logic [20:0] line;
        logic [20:0] col;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic [1:0]     n;
        tok_t [2:0]     tok;
    } step_res_t;

    // Keyword match. The stored bytes are packed right-aligned, first byte
    // highest, so they compare directly against a string literal.
    function automatic kind_t kw_lookup(input wbuf_t b, input logic [20:0] len);
        logic [KW_W-1:0] r;
        kind_t k;
        r = '0;
        for (int i = 0; i < KEYWORD_CHARS; i++)
        begin
            if (21'(i) < len)
            begin
                r = {r[KW_W-9:0], b[i]};
            end
        end
        unique case (r)
            KW_W'("SELECT"):       k = KW_SELECT;
            KW_W'("FROM"):         k = KW_FROM;
            KW_W'("WHERE"):        k = KW_WHERE;
            KW_W'("ORDER"):        k = KW_ORDER;
            KW_W'("BY"):           k = KW_BY;
            KW_W'("GROUP"):        k = KW_GROUP;
            KW_W'("HAVING"):       k = KW_HAVING;
            KW_W'("LIMIT"):        k = KW_LIMIT;
            KW_W'("OFFSET"):       k = KW_OFFSET;
            KW_W'("AS"):           k = KW_AS;
            KW_W'("AND"):          k = KW_AND;
            KW_W'("OR"):           k = KW_OR;
            KW_W'("NOT"):          k = KW_NOT;
            KW_W'("NULL"):         k = KW_NULL;
            KW_W'("TRUE"):         k = KW_TRUE;
            KW_W'("FALSE"):        k = KW_FALSE;
            KW_W'("SUM"):          k = KW_SUM;
            KW_W'("COUNT"):        k = KW_COUNT;
            KW_W'("AVG"):          k = KW_AVG;
            KW_W'("MIN"):          k = KW_MIN;
            KW_W'("MAX"):          k = KW_MAX;
            KW_W'("INSERT"):       k = KW_INSERT;
            KW_W'("INTO"):         k = KW_INTO;
            KW_W'("VALUES"):       k = KW_VALUES;
            KW_W'("CREATE"):       k = KW_CREATE;
            KW_W'("TABLE"):        k = KW_TABLE;
            KW_W'("DROP"):         k = KW_DROP;
            KW_W'("SHOW"):         k = KW_SHOW;
            KW_W'("DATABASES"):    k = KW_SHOW;
            KW_W'("DATABASE"):     k = KW_DATABASE;
            KW_W'("TABLES"):       k = KW_TABLE;
            KW_W'("DESCRIBE"):     k = KW_DESCRIBE;
            KW_W'("DESC"):         k = KW_DESC;
            KW_W'("EXPLAIN"):      k = KW_EXPLAIN;
            KW_W'("JOIN"):         k = KW_JOIN;
            KW_W'("LEFT"):         k = KW_LEFT;
            KW_W'("RIGHT"):        k = KW_RIGHT;
            KW_W'("INNER"):        k = KW_INNER;
            KW_W'("ON"):           k = KW_ON;
            KW_W'("UNION"):        k = KW_ALL;
            KW_W'("ALL"):          k = KW_ALL;
            KW_W'("WITH"):         k = KW_WITH;
            KW_W'("ROLLUP"):       k = KW_ROLLUP;
            KW_W'("ARRAY"):        k = KW_ARRAY;
            KW_W'("LATERAL"):      k = KW_LATERAL;
            KW_W'("ANY"):          k = KW_ANY;
            KW_W'("DISTINCT"):     k = KW_DISTINCT;
            KW_W'("ASC"):          k = KW_ASC;
            KW_W'("USE"):          k = KW_USE;
            KW_W'("ALTER"):        k = KW_ALTER;
            KW_W'("IF"):           k = KW_IF;
            KW_W'("EXISTS"):       k = KW_EXISTS;
            KW_W'("ENGINE"):       k = KW_ENGINE;
            KW_W'("TRUNCATE"):     k = KW_TRUNCATE;
            KW_W'("DETACH"):       k = KW_DETACH;
            KW_W'("ADD"):          k = KW_ADD;
            KW_W'("COLUMN"):       k = KW_COLUMN;
            KW_W'("MODIFY"):       k = KW_MODIFY;
            KW_W'("IN"):           k = KW_IN;
            KW_W'("OVER"):         k = KW_OVER;
            KW_W'("PARTITION"):    k = KW_PARTITION;
            KW_W'("VIEW"):         k = KW_VIEW;
            KW_W'("VIEWS"):        k = KW_VIEWS;
            KW_W'("MATERIALIZED"): k = KW_MATERIALIZED;
            KW_W'("REFRESH"):      k = KW_REFRESH;
            KW_W'("STORAGE"):      k = KW_STORAGE;
            KW_W'("UNIT"):         k = KW_UNIT;
            KW_W'("UNITS"):        k = KW_UNITS;
            KW_W'("TYPE"):         k = KW_TYPE;
            KW_W'("PATH"):         k = KW_PATH;
            KW_W'("BUCKET"):       k = KW_BUCKET;
            KW_W'("ENDPOINT"):     k = KW_ENDPOINT;
            KW_W'("REGION"):       k = KW_REGION;
            KW_W'("USAGE"):        k = KW_USAGE;
            default:               k = K_IDENT;
        endcase
        if (len > 21'(KEYWORD_CHARS))
        begin
            k = K_IDENT;
        end
        return k;
    endfunction

endpackage

[rtl/sql_token_scanner_core.sv]
// SQL token scanner. Query text enters one byte per transfer on the slave
// side, with tlast on the final byte of a query; tokens leave on the master
// side, with the token kind on tuser and tlast on the last token caused by
// one input byte. A byte is taken in the cycle it arrives whenever the output
// queue holds at most one token, so text streams at one byte per cycle as long
// as each byte yields at most one token and the consumer keeps up. A byte can
// yield up to three tokens (a flushed token, a new one and end-of-query), and
// those drain one per cycle from a four-entry output queue, which then sets
// the rate. Token text is not carried: each token gives its byte offset and
// length, plus the line and column counters when it was made. Keywords are
// matched without regard to case against a fixed table in the same cycle the
// word ends. The final byte flushes any open token, emits end-of-query unless
// three tokens came first, and resets to offset 0, line 1, column 1.
module sql_token_scanner_core
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [19:0] text_offset, [40:20] text_length,
                                   // [61:41] line_number, [82:62] column_number
    output logic [6:0]  m_tuser,   // token_kind
    output logic        m_tlast    // run_end
);

    logic      take;
    step_res_t step_res;
    tok_t      head;

    assign take = s_tvalid && s_tready;

    // Mode machine, counters and keyword lookup: one byte per cycle while the output queue has room.
    sts_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .text_byte  (s_tdata),
        .final_byte (s_tlast),
        .res        (step_res)
    );

    // Output queue decouples token bursts from the consumer.
    sts_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (take),
        .wr_res (step_res),
        .room   (s_tready),
        .valid  (m_tvalid),
        .rd     (m_tready),
        .head   (head)
    );

    assign m_tuser = head.kind;
    assign m_tlast = head.last;
    assign m_tdata = {5'd0, head.col, head.line, head.len, head.off};

endmodule

[rtl/sts_step.sv]
module sts_step
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  text_byte,
    input  logic        final_byte,
    output step_res_t   res
);

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_NUM, M_STR, M_LCOM, M_BCOM, M_BSTAR,
        M_DOT, M_SLASH, M_MINUS, M_BANG, M_LT, M_GT
    } mode_t;

    mode_t       mode_reg, mode_next;
    wbuf_t       buf_reg, buf_next;
    logic [20:0] len_reg, len_next;
    logic        sp_reg, sp_next;
    logic [19:0] pos_reg, pos_next;
    logic [19:0] ts_reg, ts_next;
    logic [20:0] line_reg, line_next;
    logic [20:0] col_reg, col_next;

    function automatic logic [20:0] col_add(input logic [20:0] c, input logic [1:0] d);
        logic [21:0] v;
        v = {1'b0, c} + 22'(d);
        return (v > {1'b0, LC_CAP}) ? LC_CAP : v[20:0];
    endfunction

    function automatic logic [20:0] len_inc(input logic [20:0] l);
        return (l < LEN_CAP) ? l + 21'd1 : l;
    endfunction

    function automatic logic [19:0] pos_inc(input logic [19:0] q);
        return (q < POS_CAP) ? q + 20'd1 : POS_CAP;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic tok_t mk(input kind_t k, input logic [19:0] o, input logic [20:0] l,
                                input logic [20:0] ln, input logic [20:0] cl);
        tok_t t;
        t.kind = k;
        t.off = o;
        t.len = l;
        t.line = ln;
        t.col = cl;
        t.last = 1'b0;
        return t;
    endfunction

    always_comb
    begin
        logic  go_idle;
        logic  lone;
        logic  pair;
        kind_t op_kind;
        kind_t kw_now;
        logic [7:0] c;
        logic [19:0] p;

        c = text_byte;
        p = pos_reg;
        mode_next = mode_reg;
        buf_next = buf_reg;
        len_next = len_reg;
        sp_next = sp_reg;
        ts_next = ts_reg;
        line_next = line_reg;
        col_next = col_reg;
        pos_next = pos_inc(p);
        res = '0;
        go_idle = 1'b0;
        lone = 1'b0;
        pair = 1'b0;
        op_kind = K_IDENT;
        kw_now = kw_lookup(buf_reg, len_reg);

        unique case (mode_reg)
            M_WORD:
            begin
                if (is_alpha(c) || is_digit(c) || c == "_")
                begin
                    if (len_next < 21'(KEYWORD_CHARS))
                    begin
                        buf_next[len_next[KW_IW-1:0]] = upcase(c);
                    end
                    len_next = len_inc(len_next);
                    col_next = col_add(col_next, 2'd1);
                end
                else
                begin
                    res.tok[res.n] = mk(kw_now, ts_next, len_next, line_next, col_next);
                    res.n = res.n + 2'd1;
                    go_idle = 1'b1;
                end
            end
            M_NUM:
            begin
                if (is_digit(c) || (c == "." && !sp_next))
                begin
                    if (c == ".")
                    begin
                        sp_next = 1'b1;
                    end
                    len_next = len_inc(len_next);
                    col_next = col_add(col_next, 2'd1);
                end
                else
                begin
                    res.tok[res.n] = mk(sp_next ? K_FLOAT : K_INTEGER, ts_next, len_next,
                                        line_next, col_next);
                    res.n = res.n + 2'd1;
                    go_idle = 1'b1;
                end
            end
            M_STR:
            begin
                col_next = col_add(col_next, 2'd1);
                if (c == "'")
                begin
                    res.tok[res.n] = mk(K_STRING, ts_next, len_next, line_next, col_next);
                    res.n = res.n + 2'd1;
                    mode_next = M_IDLE;
                end
                else
                begin
                    len_next = len_inc(len_next);
                end
            end
            M_LCOM:
            begin
                if (c == "\n")
                begin
                    go_idle = 1'b1;
                end
                else
                begin
                    col_next = col_add(col_next, 2'd1);
                end
            end
            M_BCOM, M_BSTAR:
            begin
                col_next = col_add(col_next, 2'd1);
                if (mode_reg == M_BSTAR && c == "/")
                begin
                    mode_next = M_IDLE;
                end
                else
                begin
                    mode_next = (c == "*") ? M_BSTAR : M_BCOM;
                end
            end
            M_DOT:
            begin
                if (is_digit(c))
                begin
                    mode_next = M_NUM;
                    sp_next = 1'b1;
                    len_next = 21'd2;
                    col_next = col_add(col_next, 2'd2);
                end
                else
                begin
                    lone = 1'b1;
                    op_kind = K_DOT;
                end
            end
            M_SLASH:
            begin
                if (c == "/")
                begin
                    mode_next = M_LCOM;
                end
                else if (c == "*")
                begin
                    mode_next = M_BCOM;
                end
                else
                begin
                    lone = 1'b1;
                    op_kind = K_SLASH;
                end
            end
            M_MINUS:
            begin
                op_kind = (c == ">") ? K_CONCAT : K_MINUS;
                pair = (c == ">");
                lone = !pair;
            end
            M_BANG:
            begin
                op_kind = K_NE;
                pair = (c == "=");
                lone = !pair;
            end
            M_LT:
            begin
                op_kind = (c == "=") ? K_LE : ((c == ">") ? K_NE : K_LT);
                pair = (c == "=") || (c == ">");
                lone = !pair;
            end
            M_GT:
            begin
                op_kind = (c == "=") ? K_GE : K_GT;
                pair = (c == "=");
                lone = !pair;
            end
            default:
            begin
                go_idle = 1'b1;
            end
        endcase

        if (pair)
        begin
            col_next = col_add(col_next, 2'd2);
            res.tok[res.n] = mk(op_kind, ts_next, 21'd2, line_next, col_next);
            res.n = res.n + 2'd1;
            mode_next = M_IDLE;
        end
        if (lone)
        begin
            res.tok[res.n] = mk(op_kind, ts_next, 21'd1, line_next, col_next);
            res.n = res.n + 2'd1;
            col_next = col_add(col_next, 2'd1);
            go_idle = 1'b1;
        end

        // A byte seen with no token open.
        if (go_idle)
        begin
            mode_next = M_IDLE;
            op_kind = K_IDENT;
            case (c)
                "(": op_kind = K_LPAREN;
                ")": op_kind = K_RPAREN;
                ",": op_kind = K_COMMA;
                ";": op_kind = K_SEMI;
                "*": op_kind = K_STAR;
                "+": op_kind = K_PLUS;
                "%": op_kind = K_PERCENT;
                "=": op_kind = K_EQ;
                default: op_kind = K_IDENT;
            endcase
            if (op_kind != K_IDENT)
            begin
                res.tok[res.n] = mk(op_kind, p, 21'd1, line_next, col_next);
                res.n = res.n + 2'd1;
                col_next = col_add(col_next, 2'd1);
            end
            else if (c == "." || c == "/" || c == "-" || c == "!" || c == "<" || c == ">")
            begin
                ts_next = p;
                case (c)
                    ".": mode_next = M_DOT;
                    "/": mode_next = M_SLASH;
                    "-": mode_next = M_MINUS;
                    "!": mode_next = M_BANG;
                    "<": mode_next = M_LT;
                    default: mode_next = M_GT;
                endcase
            end
            else if (is_digit(c))
            begin
                mode_next = M_NUM;
                ts_next = p;
                len_next = 21'd1;
                sp_next = 1'b0;
                col_next = col_add(col_next, 2'd1);
            end
            else if (c == "'")
            begin
                mode_next = M_STR;
                ts_next = pos_inc(p);
                len_next = 21'd0;
                col_next = col_add(col_next, 2'd1);
            end
            else if (is_alpha(c) || c == "_")
            begin
                mode_next = M_WORD;
                ts_next = p;
                buf_next[0] = upcase(c);
                len_next = 21'd1;
                col_next = col_add(col_next, 2'd1);
            end
            else if (c == "\n")
            begin
                if (line_next < LC_CAP)
                begin
                    line_next = line_next + 21'd1;
                end
                col_next = 21'd1;
            end
            else if (c == " " || (c >= 8'd9 && c <= 8'd13))
            begin
                col_next = col_add(col_next, 2'd1);
            end
            else
            begin
                col_next = col_add(col_next, 2'd1);
                res.tok[res.n] = mk(K_IDENT, p, 21'd1, line_next, col_next);
                res.n = res.n + 2'd1;
            end
        end

        // The final byte flushes whatever is open, then closes the query.
        if (final_byte)
        begin
            lone = 1'b0;
            case (mode_next)
                M_WORD:
                begin
                    res.tok[res.n] = mk(kw_lookup(buf_next, len_next), ts_next, len_next,
                                        line_next, col_next);
                    res.n = res.n + 2'd1;
                end
                M_NUM:
                begin
                    res.tok[res.n] = mk(sp_next ? K_FLOAT : K_INTEGER, ts_next, len_next,
                                        line_next, col_next);
                    res.n = res.n + 2'd1;
                end
                M_STR:
                begin
                    res.tok[res.n] = mk(K_STRING, ts_next, len_next, line_next, col_next);
                    res.n = res.n + 2'd1;
                end
                M_DOT:   begin lone = 1'b1; op_kind = K_DOT;   end
                M_SLASH: begin lone = 1'b1; op_kind = K_SLASH; end
                M_MINUS: begin lone = 1'b1; op_kind = K_MINUS; end
                M_BANG:  begin lone = 1'b1; op_kind = K_NE;    end
                M_LT:    begin lone = 1'b1; op_kind = K_LT;    end
                M_GT:    begin lone = 1'b1; op_kind = K_GT;    end
                default: lone = 1'b0;
            endcase
            if (lone)
            begin
                res.tok[res.n] = mk(op_kind, ts_next, 21'd1, line_next, col_next);
                res.n = res.n + 2'd1;
                col_next = col_add(col_next, 2'd1);
            end
            // When the byte already caused three tokens, end-of-query is dropped.
            if (res.n != 2'd3)
            begin
                res.tok[res.n] = mk(K_EOQ, pos_next, 21'd0, line_next, col_next);
                res.n = res.n + 2'd1;
            end
            mode_next = M_IDLE;
            len_next = 21'd0;
            sp_next = 1'b0;
            pos_next = 20'd0;
            ts_next = 20'd0;
            line_next = 21'd1;
            col_next = 21'd1;
        end

        if (res.n != 2'd0)
        begin
            res.tok[res.n - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            len_reg <= '0;
            sp_reg <= 1'b0;
            pos_reg <= '0;
            ts_reg <= '0;
            line_reg <= 21'd1;
            col_reg <= 21'd1;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            len_reg <= len_next;
            sp_reg <= sp_next;
            pos_reg <= pos_next;
            ts_reg <= ts_next;
            line_reg <= line_next;
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            buf_reg <= buf_next;
        end
    end

endmodule

[rtl/sts_outq.sv]
module sts_outq
    import sts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  step_res_t wr_res,
    output logic      room,
    output logic      valid,
    input  logic      rd,
    output tok_t      head
);

    tok_t       q_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] nw;

    // Space for a full step's worth of tokens is needed before a byte is taken.
    assign room = cnt_reg <= 3'd1;
    assign valid = cnt_reg != 3'd0;
    assign head = q_reg[rp_reg];
    assign nw = wr ? wr_res.n : 2'd0;
    assign cnt_next = cnt_reg + 3'(nw) - 3'(valid && rd);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < nw)
            begin
                q_reg[wp_reg + 2'(i)] <= wr_res.tok[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_reg + nw;
            rp_reg <= rp_reg + 2'(valid && rd);
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/sts_checker.sv]
module sts_checker
    import sts_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [6:0]  m_tuser,
    input logic        m_tlast
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    a_eoq_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == K_EOQ |-> m_tlast && m_tdata[40:20] == 21'd0)
        else $error("end-of-query token not last of its byte or has length");

    a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[61:41] != 21'd0 && m_tdata[82:62] != 21'd0)
        else $error("line or column counter is zero");

endmodule

bind sql_token_scanner_core sts_checker u_sts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[verif/tb_top.sv]
module tb_top;
    import sts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Expected token as seen on the master side.
    typedef struct {
        kind_t       kind;
        logic [19:0] off;
        logic [20:0] len;
        logic [20:0] line;
        logic [20:0] col;
        logic        last;
    } token_exp_t;

    // Scanner modes of the predictor.
    typedef enum int {
        SM_IDLE, SM_WORD, SM_NUM, SM_STR, SM_LCOM, SM_BCOM, SM_BSTAR,
        SM_DOT, SM_SLASH, SM_MINUS, SM_BANG, SM_LT, SM_GT
    } scan_mode_t;

    // Token predictor and scoreboard. It keeps its own copy of the scanner
    // state, turns each accepted text byte into expected tokens and checks
    // every token leaving the block against the oldest expectation.
    class token_scoreboard;
        scan_mode_t  mode;
        logic [7:0]  wbuf [KEYWORD_CHARS];
        logic [20:0] tlen;
        bit          point;
        logic [19:0] pos;
        logic [19:0] tstart;
        logic [20:0] line;
        logic [20:0] col;
        token_exp_t  pending_tokens [$];
        token_exp_t  step_tokens [$];
        int          errors;

        function void clear_state();
            mode = SM_IDLE;
            foreach (wbuf[i]) wbuf[i] = 8'h00;
            tlen = '0;
            point = 0;
            pos = '0;
            tstart = '0;
            line = 21'd1;
            col = 21'd1;
        endfunction

        function void col_add(int n);
            logic [21:0] v;
            v = 22'(col) + 22'(n);
            col = (v > 22'(LC_CAP)) ? LC_CAP : v[20:0];
        endfunction

        function logic [19:0] pos_next(logic [19:0] p);
            return (p < POS_CAP) ? p + 20'd1 : POS_CAP;
        endfunction

        function void emit(kind_t k, logic [19:0] off, logic [20:0] len);
            token_exp_t t;
            t.kind = k;
            t.off = off;
            t.len = len;
            t.line = line;
            t.col = col;
            t.last = 0;
            if (step_tokens.size() < 3) step_tokens.push_back(t);
        endfunction

        // Case-insensitive keyword lookup over the stored upper-cased bytes.
        function kind_t word_kind();
            string s;
            if (tlen > 21'(KEYWORD_CHARS)) return K_IDENT;
            s = "";
            for (int i = 0; i < tlen; i++) s = {s, string'(wbuf[i])};
            case (s)
                "SELECT": return KW_SELECT;     "FROM": return KW_FROM;
                "WHERE": return KW_WHERE;       "ORDER": return KW_ORDER;
                "BY": return KW_BY;             "GROUP": return KW_GROUP;
                "HAVING": return KW_HAVING;     "LIMIT": return KW_LIMIT;
                "OFFSET": return KW_OFFSET;     "AS": return KW_AS;
                "AND": return KW_AND;           "OR": return KW_OR;
                "NOT": return KW_NOT;           "NULL": return KW_NULL;
                "TRUE": return KW_TRUE;         "FALSE": return KW_FALSE;
                "SUM": return KW_SUM;           "COUNT": return KW_COUNT;
                "AVG": return KW_AVG;           "MIN": return KW_MIN;
                "MAX": return KW_MAX;           "INSERT": return KW_INSERT;
                "INTO": return KW_INTO;         "VALUES": return KW_VALUES;
                "CREATE": return KW_CREATE;     "TABLE": return KW_TABLE;
                "DROP": return KW_DROP;         "SHOW": return KW_SHOW;
                "DATABASES": return KW_SHOW;    "DATABASE": return KW_DATABASE;
                "TABLES": return KW_TABLE;      "DESCRIBE": return KW_DESCRIBE;
                "DESC": return KW_DESC;         "EXPLAIN": return KW_EXPLAIN;
                "JOIN": return KW_JOIN;         "LEFT": return KW_LEFT;
                "RIGHT": return KW_RIGHT;       "INNER": return KW_INNER;
                "ON": return KW_ON;             "UNION": return KW_ALL;
                "ALL": return KW_ALL;           "WITH": return KW_WITH;
                "ROLLUP": return KW_ROLLUP;     "ARRAY": return KW_ARRAY;
                "LATERAL": return KW_LATERAL;   "ANY": return KW_ANY;
                "DISTINCT": return KW_DISTINCT; "ASC": return KW_ASC;
                "USE": return KW_USE;           "ALTER": return KW_ALTER;
                "IF": return KW_IF;             "EXISTS": return KW_EXISTS;
                "ENGINE": return KW_ENGINE;     "TRUNCATE": return KW_TRUNCATE;
                "DETACH": return KW_DETACH;     "ADD": return KW_ADD;
                "COLUMN": return KW_COLUMN;     "MODIFY": return KW_MODIFY;
                "IN": return KW_IN;             "OVER": return KW_OVER;
                "PARTITION": return KW_PARTITION;
                "VIEW": return KW_VIEW;         "VIEWS": return KW_VIEWS;
                "MATERIALIZED": return KW_MATERIALIZED;
                "REFRESH": return KW_REFRESH;   "STORAGE": return KW_STORAGE;
                "UNIT": return KW_UNIT;         "UNITS": return KW_UNITS;
                "TYPE": return KW_TYPE;         "PATH": return KW_PATH;
                "BUCKET": return KW_BUCKET;     "ENDPOINT": return KW_ENDPOINT;
                "REGION": return KW_REGION;     "USAGE": return KW_USAGE;
                default: return K_IDENT;
            endcase
        endfunction

        function void word_store(logic [7:0] c);
            if (tlen < 21'(KEYWORD_CHARS))
                wbuf[tlen] = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        endfunction

        function void len_inc();
            if (tlen < LEN_CAP) tlen++;
        endfunction

        function void lone_op(kind_t k);
            emit(k, tstart, 21'd1);
            col_add(1);
            mode = SM_IDLE;
        endfunction

        function void pair_op(kind_t k);
            col_add(2);
            emit(k, tstart, 21'd2);
            mode = SM_IDLE;
        endfunction

        function void idle_byte(logic [7:0] c, logic [19:0] p);
            mode = SM_IDLE;
            case (c)
                "(": begin emit(K_LPAREN, p, 1); col_add(1); end
                ")": begin emit(K_RPAREN, p, 1); col_add(1); end
                ",": begin emit(K_COMMA, p, 1); col_add(1); end
                ";": begin emit(K_SEMI, p, 1); col_add(1); end
                "*": begin emit(K_STAR, p, 1); col_add(1); end
                "+": begin emit(K_PLUS, p, 1); col_add(1); end
                "%": begin emit(K_PERCENT, p, 1); col_add(1); end
                "=": begin emit(K_EQ, p, 1); col_add(1); end
                ".": begin mode = SM_DOT; tstart = p; end
                "/": begin mode = SM_SLASH; tstart = p; end
                "-": begin mode = SM_MINUS; tstart = p; end
                "!": begin mode = SM_BANG; tstart = p; end
                "<": begin mode = SM_LT; tstart = p; end
                ">": begin mode = SM_GT; tstart = p; end
                default:
                begin
                    if (c >= "0" && c <= "9")
                    begin
                        mode = SM_NUM; tstart = p; tlen = 1; point = 0; col_add(1);
                    end
                    else if (c == "'")
                    begin
                        mode = SM_STR; tstart = pos_next(p); tlen = 0; col_add(1);
                    end
                    else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_")
                    begin
                        mode = SM_WORD; tstart = p; tlen = 0;
                        word_store(c); tlen = 1; col_add(1);
                    end
                    else if (c == 8'h0A)
                    begin
                        if (line < LC_CAP) line++;
                        col = 21'd1;
                    end
                    else if (c == " " || (c >= 8'd9 && c <= 8'd13))
                    begin
                        col_add(1);
                    end
                    else
                    begin
                        // A byte that starts nothing is a one-byte identifier.
                        col_add(1);
                        emit(K_IDENT, p, 1);
                    end
                end
            endcase
        endfunction

        function void flush_open();
            case (mode)
                SM_WORD: emit(word_kind(), tstart, tlen);
                SM_NUM: emit(point ? K_FLOAT : K_INTEGER, tstart, tlen);
                SM_STR: emit(K_STRING, tstart, tlen);
                SM_DOT: lone_op(K_DOT);
                SM_SLASH: lone_op(K_SLASH);
                SM_MINUS: lone_op(K_MINUS);
                SM_BANG: lone_op(K_NE);
                SM_LT: lone_op(K_LT);
                SM_GT: lone_op(K_GT);
                default: ;
            endcase
            mode = SM_IDLE;
        endfunction

        // Notes one accepted text byte and queues the tokens it causes.
        function void note_byte(logic [7:0] c, bit fin);
            logic [19:0] p;
            bit wordch;
            bit digit;
            p = pos;
            pos = pos_next(p);
            step_tokens.delete();
            digit = (c >= "0" && c <= "9");
            wordch = digit || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
            case (mode)
                SM_WORD:
                    if (wordch) begin word_store(c); len_inc(); col_add(1); end
                    else begin flush_open(); idle_byte(c, p); end
                SM_NUM:
                    if (digit || (c == "." && !point))
                    begin
                        if (c == ".") point = 1;
                        len_inc(); col_add(1);
                    end
                    else begin flush_open(); idle_byte(c, p); end
                SM_STR:
                begin
                    col_add(1);
                    if (c == "'") begin emit(K_STRING, tstart, tlen); mode = SM_IDLE; end
                    else len_inc();
                end
                SM_LCOM:
                    if (c == 8'h0A) idle_byte(c, p);
                    else col_add(1);
                SM_BCOM, SM_BSTAR:
                begin
                    col_add(1);
                    if (mode == SM_BSTAR && c == "/") mode = SM_IDLE;
                    else mode = (c == "*") ? SM_BSTAR : SM_BCOM;
                end
                SM_DOT:
                    if (digit) begin mode = SM_NUM; point = 1; tlen = 2; col_add(2); end
                    else begin lone_op(K_DOT); idle_byte(c, p); end
                SM_SLASH:
                    if (c == "/") mode = SM_LCOM;
                    else if (c == "*") mode = SM_BCOM;
                    else begin lone_op(K_SLASH); idle_byte(c, p); end
                SM_MINUS:
                    if (c == ">") pair_op(K_CONCAT);
                    else begin lone_op(K_MINUS); idle_byte(c, p); end
                SM_BANG:
                    if (c == "=") pair_op(K_NE);
                    else begin lone_op(K_NE); idle_byte(c, p); end
                SM_LT:
                    if (c == "=") pair_op(K_LE);
                    else if (c == ">") pair_op(K_NE);
                    else begin lone_op(K_LT); idle_byte(c, p); end
                SM_GT:
                    if (c == "=") pair_op(K_GE);
                    else begin lone_op(K_GT); idle_byte(c, p); end
                default: idle_byte(c, p);
            endcase
            if (fin)
            begin
                flush_open();
                emit(K_EOQ, pos, 21'd0);
                clear_state();
            end
            if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1;
            foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
        endfunction

        function void check_token(kind_t k, logic [19:0] off, logic [20:0] len,
                                  logic [20:0] ln, logic [20:0] cl, logic last);
            token_exp_t e;
            if (pending_tokens.size() == 0)
            begin
                errors++;
                $display("%0t: mismatch expected no token, actual kind=%0d off=%0d",
                         $time, k, off);
                return;
            end
            e = pending_tokens.pop_front();
            if (e.kind !== k || e.off !== off || e.len !== len || e.line !== ln
                || e.col !== cl || e.last !== last)
            begin
                errors++;
                $display("%0t: mismatch expected kind=%0d off=%0d len=%0d line=%0d col=%0d last=%0d",
                         $time, e.kind, e.off, e.len, e.line, e.col, e.last);
                $display("%0t:          actual   kind=%0d off=%0d len=%0d line=%0d col=%0d last=%0d",
                         $time, k, off, len, ln, cl, last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [6:0]  m_tuser;
    logic        m_tlast;

    token_scoreboard scoreboard;
    int send_idle_pct;
    int recv_idle_pct;
    int sent_bytes;
    longint cycle_count;

    localparam longint CYCLE_LIMIT = 200000;

    sql_token_scanner_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Consumer side: ready is redrawn at each falling edge, tokens are checked
    // at the rising edge on which a transfer happens.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && m_tvalid && m_tready)
            scoreboard.check_token(kind_t'(m_tuser), m_tdata[19:0], m_tdata[40:20],
                                   m_tdata[61:41], m_tdata[82:62], m_tlast);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one text byte, with random gaps, and holds it until it is taken.
    // Valid stays high after the transfer; the next byte or an idle cycle
    // replaces it at the same falling edge.
    task automatic send_byte(logic [7:0] c, bit fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= c;
        s_tlast <= fin;
        do @(posedge clk); while (!s_tready);
        scoreboard.note_byte(c, fin);
        sent_bytes++;
        @(negedge clk);
    endtask

    task automatic send_text(string s, bit fin);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin && (i == s.len() - 1));
    endtask

    // Fragments from which random queries are assembled.
    string pieces [] = '{
        "SELECT ", "from ", "Where ", "UNION ", "databases ", "tables ",
        "materialized ", "MaterializedX ", "averylongidentifier_9 ", "x1 ", "_a ",
        "12 ", "3.14 ", ".5 ", "1.2.3 ", "'abc' ", "'' ", "->", "!=", "<>", "<=",
        ">=", "!", "<", ">", "-", ".", "/", "(", ")", ",", ";", "*", "+", "%", "=",
        "\n", "\t", "// note\n", "/* c ** x */", "/**/", "# ", "usage ", "in "
    };

    task automatic random_query();
        int n;
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                send_byte(8'($urandom), 0);
            else
                send_text(pieces[$urandom_range(pieces.size() - 1)], 0);
        end
        // The final byte is a random byte, which may fall inside an open construct.
        send_byte(8'($urandom), 1);
    endtask

    task automatic run_phase(int sp, int rp, int nbytes);
        int start_count;
        send_idle_pct = sp;
        recv_idle_pct = rp;
        start_count = sent_bytes;
        while (sent_bytes - start_count < nbytes)
        begin
            random_query();
        end
    endtask

    initial
    begin
        scoreboard = new();
        scoreboard.clear_state();
        scoreboard.errors = 0;
        cycle_count = 0;
        sent_bytes = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        m_tready = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed part: keywords, mappings, operators, numbers, an unknown
        // byte, byte extremes, a long word, and open constructs at the end.
        send_text("select Union DATABASES tables MATERIALIZED x\n", 0);
        send_text("a->b!=c<>d<=e>=f!g 1.5 .7 'it'", 1);
        send_text("materializedz", 1);
        send_byte(8'hFF, 0);
        send_byte(8'h00, 0);
        send_text("'open", 1);
        send_text("/* never closed", 1);
        send_text("x.", 1);
        send_text("/", 1);
        send_text("-", 1);
        send_text("!", 1);
        send_text("<", 1);
        send_text(">", 1);
        send_text("// tail\n(),;*+%=", 1);

        run_phase(19, 82, 50);
        run_phase(82, 19, 50);
        run_phase(0, 0, 50);
        s_tvalid <= 0;

        while (scoreboard.pending_tokens.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (scoreboard.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
